// ===== design/pga_pkg.sv =====
// Package for the PGA motor line transform: payload structs, word width and
// register indexes shared by the design and the bench.
// No dependencies.
package pga_pkg;

  localparam int WORD_BITS = 32;
  localparam int REG_BITS  = 3;
  localparam int NUM_REGS  = 8;

  localparam logic [REG_BITS-1:0] REG_SCALAR = 3'd0;
  localparam logic [REG_BITS-1:0] REG_E01    = 3'd1;
  localparam logic [REG_BITS-1:0] REG_E02    = 3'd2;
  localparam logic [REG_BITS-1:0] REG_E03    = 3'd3;
  localparam logic [REG_BITS-1:0] REG_E23    = 3'd4;
  localparam logic [REG_BITS-1:0] REG_E31    = 3'd5;
  localparam logic [REG_BITS-1:0] REG_E12    = 3'd6;
  localparam logic [REG_BITS-1:0] REG_E0123  = 3'd7;

  typedef struct packed {
    logic signed [WORD_BITS-1:0] line_e01;
    logic signed [WORD_BITS-1:0] line_e02;
    logic signed [WORD_BITS-1:0] line_e03;
    logic signed [WORD_BITS-1:0] line_e23;
    logic signed [WORD_BITS-1:0] line_e31;
    logic signed [WORD_BITS-1:0] line_e12;
  } line_in_t;

  typedef struct packed {
    logic signed [WORD_BITS-1:0] out_e01;
    logic signed [WORD_BITS-1:0] out_e02;
    logic signed [WORD_BITS-1:0] out_e03;
    logic signed [WORD_BITS-1:0] out_e23;
    logic signed [WORD_BITS-1:0] out_e31;
    logic signed [WORD_BITS-1:0] out_e12;
  } line_out_t;

endpackage

// ===== design/pga_motor_line_transform_unit.sv =====
// Top level of the PGA motor line transform: motor registers, matrix
// precompute and a pipelined 6x6 matrix-by-line product.
// Depends on pga_pkg.

// The block takes one line per cycle whenever busy is low, back to back; the
// receiver cannot stall, so the pipeline never holds. Each line gives one
// result through three register stages (line capture, products, row sums with
// saturation into the output register); the valid flag runs through v0_r, v1_r
// and v2_r alongside, and out_valid is v2_r with the result held in res_r. The
// transform matrix is formed from the motor registers through two register
// stages (pq_r, mx_r); busy is the registered mx_stale_r, which is set by each
// configuration write and held through reset, and a start held while busy is
// high is taken once busy falls.
module pga_motor_line_transform_unit
  import pga_pkg::*;
#(
  parameter int FRAC_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  line_in_t             in_data,
  output logic                 out_valid,
  output line_out_t            out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [REG_BITS-1:0]  cfg_index,
  input  logic [WORD_BITS-1:0] cfg_data
);

  localparam int PW = 2 * WORD_BITS;
  localparam int SW = PW + 4;
  localparam logic signed [SW-1:0] WMAX_S =
    SW'($signed({1'b0, {(WORD_BITS-1){1'b1}}}));
  localparam logic signed [SW-1:0] WMIN_S = -WMAX_S - SW'(1);

  typedef logic signed [WORD_BITS-1:0] word_t;

  // floor shift of a full product and saturate to a word
  function automatic word_t qsat(input logic signed [PW-1:0] p);
    logic signed [PW-1:0] s;
    begin
      s = p >>> FRAC_BITS;
      if (s > PW'(WMAX_S)) qsat = WMAX_S[WORD_BITS-1:0];
      else if (s < PW'(WMIN_S)) qsat = WMIN_S[WORD_BITS-1:0];
      else qsat = s[WORD_BITS-1:0];
    end
  endfunction

  function automatic word_t wsat(input logic signed [SW-1:0] v);
    begin
      if (v > WMAX_S) wsat = WMAX_S[WORD_BITS-1:0];
      else if (v < WMIN_S) wsat = WMIN_S[WORD_BITS-1:0];
      else wsat = v[WORD_BITS-1:0];
    end
  endfunction

  function automatic logic signed [SW-1:0] ext(input word_t w);
    ext = SW'(w);
  endfunction

  // ---------------- motor registers
  word_t mot_r [NUM_REGS];
  logic  mx_stale_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_REGS; i++)
        mot_r[i] <= (i == int'(REG_SCALAR)) ? (word_t'(1) <<< FRAC_BITS) : '0;
    end else if (cfg_valid) begin
      mot_r[cfg_index] <= cfg_data;
    end
  end
  assign cfg_ready = 1'b1;

  // hold off new lines after each motor write and through reset
  always_ff @(posedge clk) begin
    if (!rst_n) mx_stale_r <= 1'b1;
    else mx_stale_r <= cfg_valid & cfg_ready;
  end

  // ---------------- matrix stage 1: pair products
  logic signed [PW-1:0] pp [NUM_REGS][NUM_REGS];
  word_t pq_r [NUM_REGS][NUM_REGS];

  always_comb begin
    for (int a = 0; a < NUM_REGS; a++)
      for (int b = 0; b < NUM_REGS; b++)
        pp[a][b] = PW'(mot_r[a]) * PW'(mot_r[b]);
  end

  always_ff @(posedge clk) begin
    for (int a = 0; a < NUM_REGS; a++)
      for (int b = a; b < NUM_REGS; b++)
        pq_r[a][b] <= qsat(pp[a][b]);
    for (int a = 1; a < NUM_REGS; a++)
      for (int b = 0; b < a; b++)
        pq_r[a][b] <= '0;
  end

  // ---------------- matrix stage 2: entries
  word_t mx_r [6][6];
  logic signed [SW-1:0] e [6][6];

  function automatic logic signed [SW-1:0] p2(input word_t w);
    p2 = ext(w);
  endfunction

  always_comb begin
    for (int i = 0; i < 6; i++)
      for (int j = 0; j < 6; j++) e[i][j] = '0;
    e[0][0] = p2(pq_r[0][0]) + p2(pq_r[4][4]) - p2(pq_r[5][5]) - p2(pq_r[6][6]);
    e[0][1] = 2 * (p2(pq_r[0][6]) + p2(pq_r[4][5]));
    e[0][2] = 2 * (p2(pq_r[4][6]) - p2(pq_r[0][5]));
    e[1][0] = 2 * (p2(pq_r[4][5]) - p2(pq_r[0][6]));
    e[1][1] = p2(pq_r[0][0]) - p2(pq_r[4][4]) + p2(pq_r[5][5]) - p2(pq_r[6][6]);
    e[1][2] = 2 * (p2(pq_r[0][4]) + p2(pq_r[5][6]));
    e[2][0] = 2 * (p2(pq_r[0][5]) + p2(pq_r[4][6]));
    e[2][1] = 2 * (p2(pq_r[5][6]) - p2(pq_r[0][4]));
    e[2][2] = p2(pq_r[0][0]) - p2(pq_r[4][4]) - p2(pq_r[5][5]) + p2(pq_r[6][6]);
    e[0][3] = 2 * (p2(pq_r[1][4]) - p2(pq_r[0][7]) - p2(pq_r[2][5]) - p2(pq_r[3][6]));
    e[0][4] = 2 * (p2(pq_r[0][3]) + p2(pq_r[1][5]) + p2(pq_r[2][4]) - p2(pq_r[6][7]));
    e[0][5] = 2 * (p2(pq_r[1][6]) - p2(pq_r[0][2]) + p2(pq_r[3][4]) + p2(pq_r[5][7]));
    e[1][3] = 2 * (p2(pq_r[1][5]) - p2(pq_r[0][3]) + p2(pq_r[2][4]) + p2(pq_r[6][7]));
    e[1][4] = 2 * (p2(pq_r[2][5]) - p2(pq_r[0][7]) - p2(pq_r[1][4]) - p2(pq_r[3][6]));
    e[1][5] = 2 * (p2(pq_r[0][1]) + p2(pq_r[2][6]) + p2(pq_r[3][5]) - p2(pq_r[4][7]));
    e[2][3] = 2 * (p2(pq_r[0][2]) + p2(pq_r[1][6]) + p2(pq_r[3][4]) - p2(pq_r[5][7]));
    e[2][4] = 2 * (p2(pq_r[2][6]) - p2(pq_r[0][1]) + p2(pq_r[3][5]) + p2(pq_r[4][7]));
    e[2][5] = 2 * (p2(pq_r[3][6]) - p2(pq_r[0][7]) - p2(pq_r[2][5]) - p2(pq_r[1][4]));
    // lower-right block repeats the rotation
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) e[i+3][j+3] = e[i][j];
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 6; i++)
      for (int j = 0; j < 6; j++) mx_r[i][j] <= wsat(e[i][j]);
  end

  // ---------------- datapath stage 0: capture line
  logic  v0_r, v1_r, v2_r;
  word_t l_r [6];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else begin
      v0_r <= start & ~busy;
    end
    l_r[0] <= in_data.line_e01;
    l_r[1] <= in_data.line_e02;
    l_r[2] <= in_data.line_e03;
    l_r[3] <= in_data.line_e23;
    l_r[4] <= in_data.line_e31;
    l_r[5] <= in_data.line_e12;
  end

  // ---------------- stage 1: 36 products
  word_t q_r [6][6];

  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else v1_r <= v0_r;
    for (int i = 0; i < 6; i++)
      for (int j = 0; j < 6; j++)
        q_r[i][j] <= qsat(PW'(mx_r[i][j]) * PW'(l_r[j]));
  end

  // ---------------- stage 2: row sums and saturation
  logic signed [SW-1:0] acc [6];
  line_out_t res_r;

  always_comb begin
    for (int i = 0; i < 6; i++) begin
      acc[i] = '0;
      for (int j = 0; j < 6; j++) acc[i] = acc[i] + ext(q_r[i][j]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v2_r <= 1'b0;
    else v2_r <= v1_r;
    res_r.out_e01 <= wsat(acc[0]);
    res_r.out_e02 <= wsat(acc[1]);
    res_r.out_e03 <= wsat(acc[2]);
    res_r.out_e23 <= wsat(acc[3]);
    res_r.out_e31 <= wsat(acc[4]);
    res_r.out_e12 <= wsat(acc[5]);
  end

  assign busy      = mx_stale_r;
  assign out_valid = v2_r;
  assign out_data  = res_r;

  // ---------------- checks
  a_v1_follows: assert property (@(posedge clk) disable iff (!rst_n)
    v0_r |=> v1_r) else $error("beat lost between stages");
  a_out_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##3 out_valid) else $error("result missing");
  a_no_ghost: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(v1_r)) else $error("result without item");

endmodule

// ===== bench/pga_motor_line_transform_unit_test.sv =====
// Regression bench for the PGA motor line transform: directed and random
// lines under several motor settings, checked against a fixed-point predictor.
// Depends on pga_pkg and pga_motor_line_transform_unit.
`timescale 1ns / 100ps

module pga_motor_line_transform_unit_test
  import pga_pkg::*;
();

  localparam longint WORD_MAX = 64'sd2147483647;
  localparam longint WORD_MIN = -64'sd2147483648;
  localparam logic signed [31:0] ONE_Q = 32'sd65536;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  line_in_t             in_data = '0;
  logic                 out_valid;
  line_out_t            out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [REG_BITS-1:0]  cfg_index = '0;
  logic [31:0]          cfg_data = '0;

  logic signed [31:0]   motor [NUM_REGS];
  line_out_t            pending_lines [$];
  int                   fail_count = 0;

  typedef struct {
    line_in_t  line;
    bit        typed;
    line_out_t want;
  } line_row_t;

  pga_motor_line_transform_unit i_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    #2ms;
    $display("pga_motor_line_transform_unit regression: fail");
    $finish;
  end

  function automatic longint clamp_word(longint v);
    if (v > WORD_MAX) return WORD_MAX;
    if (v < WORD_MIN) return WORD_MIN;
    return v;
  endfunction

  // floor of the product shifted back by the fraction bits, then clamp
  function automatic longint fix_mul(longint a, longint b);
    return clamp_word((a * b) >>> 16);
  endfunction

  function automatic line_out_t transform_line(line_in_t ln);
    longint m [8];
    longint l [6];
    longint r [3][3];
    longint t [3][3];
    longint acc [6];
    logic [5:0][31:0] res;
    for (int i = 0; i < 8; i++) m[i] = motor[i];
    l[0] = ln.line_e01; l[1] = ln.line_e02; l[2] = ln.line_e03;
    l[3] = ln.line_e23; l[4] = ln.line_e31; l[5] = ln.line_e12;
    r[0][0] = clamp_word(fix_mul(m[0],m[0]) + fix_mul(m[4],m[4]) - fix_mul(m[5],m[5])
                         - fix_mul(m[6],m[6]));
    r[0][1] = clamp_word(2 * (fix_mul(m[0],m[6]) + fix_mul(m[4],m[5])));
    r[0][2] = clamp_word(2 * (fix_mul(m[4],m[6]) - fix_mul(m[0],m[5])));
    r[1][0] = clamp_word(2 * (fix_mul(m[4],m[5]) - fix_mul(m[0],m[6])));
    r[1][1] = clamp_word(fix_mul(m[0],m[0]) - fix_mul(m[4],m[4]) + fix_mul(m[5],m[5])
                         - fix_mul(m[6],m[6]));
    r[1][2] = clamp_word(2 * (fix_mul(m[0],m[4]) + fix_mul(m[5],m[6])));
    r[2][0] = clamp_word(2 * (fix_mul(m[0],m[5]) + fix_mul(m[4],m[6])));
    r[2][1] = clamp_word(2 * (fix_mul(m[5],m[6]) - fix_mul(m[0],m[4])));
    r[2][2] = clamp_word(fix_mul(m[0],m[0]) - fix_mul(m[4],m[4]) - fix_mul(m[5],m[5])
                         + fix_mul(m[6],m[6]));
    t[0][0] = clamp_word(2 * (fix_mul(m[1],m[4]) - fix_mul(m[0],m[7])
                              - fix_mul(m[2],m[5]) - fix_mul(m[3],m[6])));
    t[0][1] = clamp_word(2 * (fix_mul(m[0],m[3]) + fix_mul(m[1],m[5])
                              + fix_mul(m[2],m[4]) - fix_mul(m[6],m[7])));
    t[0][2] = clamp_word(2 * (fix_mul(m[1],m[6]) - fix_mul(m[0],m[2])
                              + fix_mul(m[3],m[4]) + fix_mul(m[5],m[7])));
    t[1][0] = clamp_word(2 * (fix_mul(m[1],m[5]) - fix_mul(m[0],m[3])
                              + fix_mul(m[2],m[4]) + fix_mul(m[6],m[7])));
    t[1][1] = clamp_word(2 * (fix_mul(m[2],m[5]) - fix_mul(m[0],m[7])
                              - fix_mul(m[1],m[4]) - fix_mul(m[3],m[6])));
    t[1][2] = clamp_word(2 * (fix_mul(m[0],m[1]) + fix_mul(m[2],m[6])
                              + fix_mul(m[3],m[5]) - fix_mul(m[4],m[7])));
    t[2][0] = clamp_word(2 * (fix_mul(m[0],m[2]) + fix_mul(m[1],m[6])
                              + fix_mul(m[3],m[4]) - fix_mul(m[5],m[7])));
    t[2][1] = clamp_word(2 * (fix_mul(m[2],m[6]) - fix_mul(m[0],m[1])
                              + fix_mul(m[3],m[5]) + fix_mul(m[4],m[7])));
    t[2][2] = clamp_word(2 * (fix_mul(m[3],m[6]) - fix_mul(m[0],m[7])
                              - fix_mul(m[2],m[5]) - fix_mul(m[1],m[4])));
    for (int i = 0; i < 3; i++) begin
      acc[i] = 0;
      acc[i+3] = 0;
      for (int j = 0; j < 3; j++) begin
        acc[i] += fix_mul(r[i][j], l[j]) + fix_mul(t[i][j], l[j+3]);
        acc[i+3] += fix_mul(r[i][j], l[j+3]);
      end
    end
    for (int i = 0; i < 6; i++) res[5-i] = 32'(clamp_word(acc[i]));
    return line_out_t'(res);
  endfunction

  // Track motor writes and accepted lines; values seen here are pre-edge.
  always @(posedge clk) begin
    if (rst_n && cfg_valid && cfg_ready) motor[cfg_index] <= cfg_data;
    if (rst_n && start && !busy) pending_lines.push_back(transform_line(in_data));
  end

  always @(posedge clk) begin
    logic [5:0][31:0] want_w;
    logic [5:0][31:0] got_w;
    if (rst_n && out_valid) begin
      if (pending_lines.size() == 0) begin
        $display("%0t: unexpected result line %h", $time, out_data);
        fail_count++;
      end else begin
        want_w = pending_lines.pop_front();
        got_w = out_data;
        for (int f = 5; f >= 0; f--)
          if (want_w[f] !== got_w[f]) begin
            $display("%0t: field %0d expected %h actual %h", $time, 5 - f,
                     want_w[f], got_w[f]);
            fail_count++;
          end
      end
    end
  end

  function automatic logic [31:0] pick_word(bit full);
    if (full) return $urandom;
    // mostly within +-2.0 so that products stay clear of the clamp
    return 32'($urandom_range(0, 32'h0004_0000)) - 32'h0002_0000;
  endfunction

  // hold the beat until an edge at which busy was low
  task automatic send_line(line_in_t ln, int gap);
    bit taken;
    start <= 1'b1;
    in_data <= ln;
    do begin
      @(negedge clk);
      taken = !busy;
      @(posedge clk);
    end while (!taken);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic settle();
    if (start) begin
      start <= 1'b0;
      @(posedge clk);
    end
    wait (pending_lines.size() == 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic load_motor(logic [31:0] vals [8]);
    settle();
    for (int i = 0; i < NUM_REGS; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= REG_BITS'(i);
      cfg_data <= vals[i];
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
    // let the matrix registers catch up with the new motor
    repeat (4) @(posedge clk);
  endtask

  task automatic stream_random(int count, bit full_share);
    line_in_t ln;
    bit no_idle;
    for (int n = 0; n < count; n++) begin
      if (n % 40 == 0) no_idle = ($urandom_range(0, 2) == 0);
      ln.line_e01 = pick_word(full_share && $urandom_range(0, 3) == 0);
      ln.line_e02 = pick_word(full_share && $urandom_range(0, 3) == 0);
      ln.line_e03 = pick_word(full_share && $urandom_range(0, 3) == 0);
      ln.line_e23 = pick_word(full_share && $urandom_range(0, 3) == 0);
      ln.line_e31 = pick_word(full_share && $urandom_range(0, 3) == 0);
      ln.line_e12 = pick_word(full_share && $urandom_range(0, 3) == 0);
      send_line(ln, no_idle ? 0 : $urandom_range(0, 11));
    end
  endtask

  initial begin
    line_row_t rows [$];
    line_row_t row;
    logic [31:0] mv [8];
    logic [31:0] words [6];
    line_out_t pred;
    for (int i = 0; i < NUM_REGS; i++) motor[i] = 0;
    motor[REG_SCALAR] = ONE_Q;

    // Identity motor after reset: every line passes through unchanged.
    words = '{32'h7fff_ffff, 32'h8000_0000, 32'h0000_0000, 32'hffff_ffff,
              32'h0001_0000, 32'hffff_0000};
    for (int k = 0; k < 6; k++) begin
      row.line = {words[k], words[(k+1)%6], words[(k+2)%6], words[(k+3)%6],
                  words[(k+4)%6], words[(k+5)%6]};
      row.typed = 1'b1;
      row.want = line_out_t'(row.line);
      rows.push_back(row);
    end
    row.line = {6{32'h7fff_ffff}}; row.want = line_out_t'(row.line); rows.push_back(row);
    row.line = {6{32'h8000_0000}}; row.want = line_out_t'(row.line); rows.push_back(row);
    row.line = '0;                 row.want = '0;                    rows.push_back(row);
    row.typed = 1'b0;
    for (int k = 0; k < 6; k++) begin
      row.line = {6{32'h5555_aaaa}} ^ {6{32'($urandom)}};
      rows.push_back(row);
    end

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (rows[k]) begin
      if (rows[k].typed) begin
        pred = transform_line(rows[k].line);
        if (pred !== rows[k].want) begin
          $display("%0t: row %0d expected %h actual %h", $time, k, rows[k].want,
                   pred);
          fail_count++;
        end
      end
      send_line(rows[k].line, $urandom_range(0, 11));
    end

    // Clamp extremes: all maximum, all minimum, zero motor.
    mv = '{default: 32'h7fff_ffff}; load_motor(mv); stream_random(20, 1);
    mv = '{default: 32'h8000_0000}; load_motor(mv); stream_random(20, 1);
    mv = '{default: 32'h0};         load_motor(mv); stream_random(10, 1);

    // Random motors within +-2.0 with random content, then two motors at full range.
    for (int ph = 0; ph < 10; ph++) begin
      for (int i = 0; i < NUM_REGS; i++) mv[i] = pick_word(ph >= 8);
      load_motor(mv);
      stream_random(90, ph % 2);
    end

    settle();
    if (fail_count == 0) begin
      $display("pga_motor_line_transform_unit regression: pass");
    end else begin
      $display("pga_motor_line_transform_unit regression: fail");
    end
    $finish;
  end

endmodule
